FILE: hdl/ckx_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ckx_pkg: shared definitions for the ChaCha keystream XOR block
// Widths, cipher constants, sub-step codes and the rotate helper used by the
// sequencer and by the shared mixing unit.
// ----------------------------------------------------------------------------
package ckx_pkg;

  localparam int BLOCK_BYTES = 64;
  localparam int POS_W       = $clog2(BLOCK_BYTES);
  localparam int WORDS       = 16;
  localparam int WIDX_W      = $clog2(WORDS);

  localparam int DATA_W      = 8;
  localparam int NONCE_W     = 64;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 8;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int ROUNDS_W    = 5;
  localparam int DR_W        = ROUNDS_W - 1;
  localparam int QR_W        = 3;

  localparam logic [ROUNDS_W-1:0] ROUNDS_RESET = 5'd20;

  // "expand 32-byte k"
  localparam logic [31:0] SIGMA0 = 32'h6578_7061;
  localparam logic [31:0] SIGMA1 = 32'h6e64_2033;
  localparam logic [31:0] SIGMA2 = 32'h322d_6279;
  localparam logic [31:0] SIGMA3 = 32'h7465_206b;

  // Configuration register indexes.
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_KEY01  = 3'd0,
    CFG_KEY23  = 3'd1,
    CFG_KEY45  = 3'd2,
    CFG_KEY67  = 3'd3,
    CFG_ROUNDS = 3'd4,
    CFG_START  = 3'd5
  } ckx_cfg_idx_t;

  // The four add/xor/rotate steps of one quarter round, named by the word
  // that takes the sum and the rotate distance.
  typedef enum logic [1:0] {
    SUB_A16 = 2'd0,
    SUB_C12 = 2'd1,
    SUB_A8  = 2'd2,
    SUB_C7  = 2'd3
  } ckx_sub_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    ckx_sub_t    sub;
  } ckx_mix_in_t;

  function automatic logic [31:0] ckx_rotl(input logic [31:0] v, input ckx_sub_t sub);
    logic [31:0] r;
    unique case (sub)
      SUB_A16: r = {v[15:0], v[31:16]};
      SUB_C12: r = {v[19:0], v[31:20]};
      SUB_A8:  r = {v[23:0], v[31:24]};
      SUB_C7:  r = {v[24:0], v[31:25]};
      default: r = v;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/ckx_mix_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ckx_mix_unit: shared add, xor and rotate unit
// Computes sum = x + y and mix = rotl(z ^ sum, n) for one quarter-round step.
// The sum alone also serves the feed-forward addition.
// ----------------------------------------------------------------------------
module ckx_mix_unit (
  input  ckx_pkg::ckx_mix_in_t op,
  output logic [31:0]          sum,
  output logic [31:0]          mix
);
  import ckx_pkg::*;

  always_comb begin
    sum = op.x + op.y;
    mix = ckx_rotl(op.z ^ sum, op.sub);
  end

endmodule
`default_nettype wire

FILE: hdl/chacha_keystream_xor.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chacha_keystream_xor: byte-serial ChaCha keystream XOR
// Encrypts or decrypts one byte per transaction with a ChaCha keystream built
// from a 256-bit key, a 64-bit block counter and a 64-bit nonce.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Contents
//  --------+-----------+------------------------------------------------------
//  in_     | slave     | tdata: data_byte[7:0], nonce[71:8]; tlast: final_byte
//  out_    | master    | tdata: result_byte[7:0]
//  cfg_    | write     | cfg_addr selects register, cfg_wdata holds its value
//
//  A byte that continues a keystream block is accepted, then loaded into the output.
//  A byte that opens a block first runs floor(round_count / 2) double rounds: one
//  shared add/xor/rotate unit does one quarter-round step a cycle, then reuses its
//  adder for the feed-forward addition of all 16 words.
//  Reset is synchronous and active low; a stalled output holds its byte, and the
//  next byte is accepted but waits in the sequencer until the output frees up.
//
module chacha_keystream_xor (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input channel.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [ckx_pkg::IN_TDATA_W-1:0]      in_tdata,   // data_byte[7:0], nonce[71:8]
  input  logic                                in_tlast,
  // Result channel.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [ckx_pkg::OUT_TDATA_W-1:0]     out_tdata,  // result_byte[7:0]
  // Configuration write port.
  input  logic                                cfg_we,
  input  logic [ckx_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [ckx_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import ckx_pkg::*;

  // One-hot sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_LOAD  = 5'b00010,
    ST_ROUND = 5'b00100,
    ST_FEED  = 5'b01000,
    ST_EMIT  = 5'b10000
  } ckx_state_t;

  ckx_state_t state_r, state_nxt;

  // Configuration registers.
  logic [63:0]          key_r [4];
  logic [ROUNDS_W-1:0]  rounds_r;
  logic [63:0]          start_r;

  // Message and block bookkeeping.
  logic [63:0]          ctr_r, ctr_nxt;
  logic [POS_W-1:0]     bpos_r, bpos_nxt;
  logic                 open_r, open_nxt;

  // Captured transaction payload.
  logic [DATA_W-1:0]    data_r;
  logic [NONCE_W-1:0]   nonce_r;
  logic [POS_W-1:0]     pos_r;

  // Working state; after the feed-forward it holds the keystream block.
  logic [31:0]          w_r   [WORDS];
  logic [31:0]          w_nxt [WORDS];
  logic [31:0]          init_w [WORDS];

  // Round sequencer counters.
  ckx_sub_t             sub_r, sub_nxt;
  logic [QR_W-1:0]      qr_r, qr_nxt;
  logic [DR_W-1:0]      dr_r, dr_nxt;
  logic [WIDX_W-1:0]    feed_r, feed_nxt;

  // Output register.
  logic                 out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]    out_data_r, out_data_nxt;

  logic                 in_acc;
  logic [POS_W-1:0]     acc_pos;
  logic [DR_W-1:0]      dr_count;
  logic                 out_free;
  logic [31:0]          ks_word;
  ckx_mix_in_t          mix_op;
  logic [31:0]          mix_sum, mix_val;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_free   = !out_valid_r || out_tready;
  assign dr_count   = rounds_r[ROUNDS_W-1:1];

  // A closed message starts over at byte zero of a fresh block.
  assign acc_pos = open_r ? bpos_r : '0;

  // Block input state, rebuilt from the latched counter and nonce.
  always_comb begin
    init_w[0]  = SIGMA0;
    init_w[1]  = SIGMA1;
    init_w[2]  = SIGMA2;
    init_w[3]  = SIGMA3;
    for (int k = 0; k < 4; k++) begin
      init_w[4 + 2*k] = key_r[k][31:0];
      init_w[5 + 2*k] = key_r[k][63:32];
    end
    init_w[12] = ctr_r[31:0];
    init_w[13] = ctr_r[63:32];
    init_w[14] = nonce_r[31:0];
    init_w[15] = nonce_r[63:32];
  end

  // Operand selection for the shared unit. The quarter round always works
  // on column 0 (words 0, 4, 8, 12); the rows are rotated after each quarter
  // round so that the next column or diagonal moves into that place.
  always_comb begin
    mix_op.sub = sub_r;
    if (state_r == ST_FEED) begin
      mix_op.x = w_r[0];
      mix_op.y = init_w[feed_r];
      mix_op.z = '0;
    end else if (sub_r == SUB_A16 || sub_r == SUB_A8) begin
      mix_op.x = w_r[0];
      mix_op.y = w_r[4];
      mix_op.z = w_r[12];
    end else begin
      mix_op.x = w_r[8];
      mix_op.y = w_r[12];
      mix_op.z = w_r[4];
    end
  end

  ckx_mix_unit u_mix (
    .op  (mix_op),
    .sum (mix_sum),
    .mix (mix_val)
  );

  assign ks_word = w_r[pos_r[POS_W-1:2]];

  // Sequencer and datapath next-state logic.
  always_comb begin
    logic [31:0] wa [WORDS];
    logic [1:0]  amt;
    logic [1:0]  src;

    state_nxt     = state_r;
    ctr_nxt       = ctr_r;
    bpos_nxt      = bpos_r;
    open_nxt      = open_r;
    sub_nxt       = sub_r;
    qr_nxt        = qr_r;
    dr_nxt        = dr_r;
    feed_nxt      = feed_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    amt           = 2'd0;
    src           = 2'd0;
    for (int i = 0; i < WORDS; i++) begin
      w_nxt[i] = w_r[i];
      wa[i]    = w_r[i];
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          open_nxt = !in_tlast;
          bpos_nxt = in_tlast ? '0 : acc_pos + POS_W'(1);
          if (acc_pos == '0) begin
            // New block: step the counter, from start_counter on a new message.
            ctr_nxt   = (open_r ? ctr_r : start_r) + 64'd1;
            state_nxt = ST_LOAD;
          end else begin
            state_nxt = ST_EMIT;
          end
        end
      end

      ST_LOAD: begin
        for (int i = 0; i < WORDS; i++) begin
          w_nxt[i] = init_w[i];
        end
        sub_nxt   = SUB_A16;
        qr_nxt    = '0;
        dr_nxt    = '0;
        feed_nxt  = '0;
        state_nxt = (dr_count == '0) ? ST_FEED : ST_ROUND;
      end

      ST_ROUND: begin
        if (sub_r == SUB_A16 || sub_r == SUB_A8) begin
          wa[0]  = mix_sum;
          wa[12] = mix_val;
        end else begin
          wa[8]  = mix_sum;
          wa[4]  = mix_val;
        end
        sub_nxt = ckx_sub_t'(sub_r + 2'd1);
        if (sub_r == SUB_C7) begin
          // Move the next column into place. After the last column the rows
          // are also diagonalized, after the last diagonal they are restored.
          for (int r = 0; r < 4; r++) begin
            if (qr_r == QR_W'(3)) begin
              amt = 2'(1 + r);
            end else if (qr_r == QR_W'(7)) begin
              amt = 2'(1 - r);
            end else begin
              amt = 2'd1;
            end
            for (int j = 0; j < 4; j++) begin
              src = 2'(j) + amt;
              w_nxt[4*r + j] = wa[4*r + int'(src)];
            end
          end
          qr_nxt = qr_r + QR_W'(1);
          if (qr_r == QR_W'(7)) begin
            dr_nxt = dr_r + DR_W'(1);
            if (dr_r == dr_count - DR_W'(1)) begin
              state_nxt = ST_FEED;
            end
          end
        end else begin
          for (int i = 0; i < WORDS; i++) begin
            w_nxt[i] = wa[i];
          end
        end
      end

      ST_FEED: begin
        // Add the input state back, one word a cycle, shifting the words
        // through position 0 so that order is restored once all 16 are added.
        for (int i = 0; i < WORDS - 1; i++) begin
          w_nxt[i] = w_r[i + 1];
        end
        w_nxt[WORDS-1] = mix_sum;
        feed_nxt       = feed_r + WIDX_W'(1);
        if (feed_r == WIDX_W'(WORDS - 1)) begin
          state_nxt = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = data_r ^ ks_word[8*pos_r[1:0] +: 8];
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ctr_r       <= '0;
      bpos_r      <= '0;
      open_r      <= 1'b0;
      sub_r       <= SUB_A16;
      qr_r        <= '0;
      dr_r        <= '0;
      feed_r      <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < 4; k++) begin
        key_r[k] <= '0;
      end
      rounds_r    <= ROUNDS_RESET;
      start_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      ctr_r       <= ctr_nxt;
      bpos_r      <= bpos_nxt;
      open_r      <= open_nxt;
      sub_r       <= sub_nxt;
      qr_r        <= qr_nxt;
      dr_r        <= dr_nxt;
      feed_r      <= feed_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_KEY01:  key_r[0] <= cfg_wdata;
          CFG_KEY23:  key_r[1] <= cfg_wdata;
          CFG_KEY45:  key_r[2] <= cfg_wdata;
          CFG_KEY67:  key_r[3] <= cfg_wdata;
          CFG_ROUNDS: rounds_r <= cfg_wdata[ROUNDS_W-1:0];
          CFG_START:  start_r  <= cfg_wdata;
          default:    ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    for (int i = 0; i < WORDS; i++) begin
      w_r[i] <= w_nxt[i];
    end
    if (in_acc) begin
      data_r <= in_tdata[DATA_W-1:0];
      pos_r  <= acc_pos;
      if (acc_pos == '0) begin
        nonce_r <= in_tdata[DATA_W +: NONCE_W];
      end
    end
  end

endmodule
`default_nettype wire

FILE: hdl/ckx_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ckx_checker: port-level checks for the ChaCha keystream XOR block
// Tracks transactions in flight and checks output behavior over time.
// ----------------------------------------------------------------------------
module ckx_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [ckx_pkg::OUT_TDATA_W-1:0] out_tdata
);
  logic [2:0] pend_r, pend_nxt;
  logic       in_acc, out_acc;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  always_comb begin
    pend_nxt = pend_r + 3'(in_acc) - 3'(out_acc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // The output is empty right after reset.
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // A stalled result holds its byte.
  assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // Input ready drops after every accepted byte, while that byte is processed.
  assert property (@(posedge clk) rst_n && in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after a transaction");

  // A result is only offered for a byte that was taken in.
  assert property (@(posedge clk) disable iff (!rst_n) out_tvalid |-> pend_r != 3'd0)
    else $error("result without a pending input");

  // At most one byte in the sequencer and one in the output register.
  assert property (@(posedge clk) disable iff (!rst_n) pend_r <= 3'd2)
    else $error("too many transactions in flight");

endmodule

bind chacha_keystream_xor ckx_checker u_ckx_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

FILE: tb/sv/tb_chacha_keystream_xor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_chacha_keystream_xor: self-checking bench for the ChaCha keystream XOR
// A scoreboard class recomputes every keystream block in software and checks
// each result byte in order. The test starts with directed messages, then runs
// random configuration phases with mostly well-formed messages and some noise.
// ----------------------------------------------------------------------------
module tb_chacha_keystream_xor;
  import ckx_pkg::*;

  localparam int RANDOM_ITEMS = 1450;
  // A block that opens at 31 rounds is the slowest; even if every byte
  // opened one and met the longest gap and stall, the run stays far below this.
  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int MAX_REPORTS  = 50;

  // --------------------------------------------------------------------------
  // Scoreboard: a software copy of the cipher state plus the queue of result
  // bytes that the block still owes.
  // --------------------------------------------------------------------------
  class keystream_scoreboard;
    logic [63:0] key_pair [4];
    logic [4:0]  rounds;
    logic [63:0] start_ctr;
    logic [31:0] keystream [16];
    logic [31:0] mix [16];
    logic [63:0] blk_ctr;
    logic [5:0]  pos;
    bit          msg_open;
    logic [7:0]  expected_bytes [$];
    int          errors;

    function new();
      foreach (key_pair[i]) key_pair[i] = '0;
      rounds    = 5'd20;
      start_ctr = '0;
      blk_ctr   = '0;
      pos       = '0;
      msg_open  = 1'b0;
      errors    = 0;
    endfunction

    function void write_reg(ckx_cfg_idx_t idx, logic [63:0] val);
      case (idx)
        CFG_KEY01:  key_pair[0] = val;
        CFG_KEY23:  key_pair[1] = val;
        CFG_KEY45:  key_pair[2] = val;
        CFG_KEY67:  key_pair[3] = val;
        CFG_ROUNDS: rounds = val[4:0];
        CFG_START:  start_ctr = val;
        default: ;
      endcase
    endfunction

    function logic [31:0] rotl(logic [31:0] v, int n);
      return (v << n) | (v >> (32 - n));
    endfunction

    function void quarter(int a, int b, int c, int d);
      mix[a] += mix[b]; mix[d] = rotl(mix[d] ^ mix[a], 16);
      mix[c] += mix[d]; mix[b] = rotl(mix[b] ^ mix[c], 12);
      mix[a] += mix[b]; mix[d] = rotl(mix[d] ^ mix[a], 8);
      mix[c] += mix[d]; mix[b] = rotl(mix[b] ^ mix[c], 7);
    endfunction

    // Builds the 64-byte keystream block for the current counter and nonce.
    function void expand_block(logic [63:0] nonce);
      logic [31:0] init [16];
      init[0] = 32'h6578_7061;
      init[1] = 32'h6e64_2033;
      init[2] = 32'h322d_6279;
      init[3] = 32'h7465_206b;
      for (int k = 0; k < 4; k++) begin
        init[4 + 2*k] = key_pair[k][31:0];
        init[5 + 2*k] = key_pair[k][63:32];
      end
      init[12] = blk_ctr[31:0];
      init[13] = blk_ctr[63:32];
      init[14] = nonce[31:0];
      init[15] = nonce[63:32];
      mix = init;
      for (int dr = 0; dr < (rounds >> 1); dr++) begin
        quarter(0, 4, 8, 12);
        quarter(1, 5, 9, 13);
        quarter(2, 6, 10, 14);
        quarter(3, 7, 11, 15);
        quarter(0, 5, 10, 15);
        quarter(1, 6, 11, 12);
        quarter(2, 7, 8, 13);
        quarter(3, 4, 9, 14);
      end
      for (int k = 0; k < 16; k++) keystream[k] = mix[k] + init[k];
    endfunction

    function void note_input(logic [7:0] data, logic [63:0] nonce, logic last);
      logic [31:0] word;
      if (!msg_open) begin
        blk_ctr  = start_ctr;
        msg_open = 1'b1;
        pos      = '0;
      end
      if (pos == 6'd0) begin
        blk_ctr += 64'd1;
        expand_block(nonce);
      end
      word = keystream[pos[5:2]];
      expected_bytes.insert(expected_bytes.size(), data ^ word[pos[1:0]*8 +: 8]);
      pos = pos + 6'd1;
      if (last) begin
        msg_open = 1'b0;
        pos      = '0;
      end
    endfunction

    function void check_result(logic [7:0] got);
      logic [7:0] want;
      if (expected_bytes.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result byte, expected none, actual %02h", $time, got);
        return;
      end
      want = expected_bytes.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result_byte mismatch, expected %02h, actual %02h", $time, want, got);
      end
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the signals that drive the block. Everything the bench
  // drives starts at a known value at time zero.
  // --------------------------------------------------------------------------
  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;   // data_byte[7:0], nonce[71:8]
  logic                   in_tlast   = 1'b0; // final_byte
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // result_byte[7:0]
  logic                   cfg_we     = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr   = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;

  keystream_scoreboard sb = new();

  int cycles      = 0;
  int items_sent  = 0;
  int in_gap_max  = 8;
  int out_gap_max = 8;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  chacha_keystream_xor i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // A hang anywhere ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Transactions are observed in the active region of the rising edge, so
  // every signal read here still holds its value from before the edge. The
  // input side is noted first; a result can never belong to a byte that is
  // accepted at the same edge.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      sb.note_input(in_tdata[7:0], in_tdata[71:8], in_tlast);
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata);
  end

  // Result side: before each transaction it holds tready low for a random
  // number of cycles, unless the current phase runs without stalls.
  initial begin
    int stall;
    forever begin
      stall = (out_gap_max == 0) ? 0 : $urandom_range(0, out_gap_max);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  // --------------------------------------------------------------------------
  // Driving tasks.
  // --------------------------------------------------------------------------

  // Presents one byte and returns at the edge where it is accepted. tvalid
  // only drops when a gap follows, so back-to-back bytes keep it high.
  task automatic send_byte(input logic [7:0] data, input logic [63:0] nonce,
                           input logic last);
    int gap;
    gap = (in_gap_max == 0) ? 0 : $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {nonce, data};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // Stops sending and waits until every owed byte has come back. Every byte
  // yields a result, so once the queue is empty the block is idle.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes leave cfg_we high so that back-to-back writes never lower and
  // raise it in one step; end_writes closes a batch.
  task automatic write_reg(input ckx_cfg_idx_t idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic end_writes();
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Wide values lean on the extremes and on the 32-bit carry boundary.
  function automatic logic [63:0] pick_wide();
    case ($urandom_range(0, 7))
      0:       return 64'h0;
      1:       return 64'hFFFF_FFFF_FFFF_FFFF;
      2:       return 64'h0000_0000_FFFF_FFFF;
      3:       return 64'hFFFF_FFFF_FFFF_FFFE;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  function automatic logic [63:0] pick_rounds();
    case ($urandom_range(0, 7))
      0:       return 64'd0;
      1:       return 64'd1;
      2:       return 64'd2;
      3:       return 64'd20;
      4:       return 64'd31;
      default: return 64'($urandom_range(0, 31));
    endcase
  endfunction

  // One message: usually a run of bytes with one nonce that closes with a
  // final byte, sometimes left open so that the next message continues mid-block,
  // and sometimes noise with a fresh nonce and random final flags per byte.
  task automatic send_message();
    int          kind;
    int          len;
    logic [63:0] nonce;
    kind  = $urandom_range(0, 9);
    nonce = pick_wide();
    if (kind == 0) begin
      len = $urandom_range(1, 8);
      for (int k = 0; k < len; k++)
        send_byte(8'($urandom_range(0, 255)), pick_wide(), 1'($urandom_range(0, 1)));
    end else begin
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 70);
      for (int k = 0; k < len; k++)
        send_byte(8'($urandom_range(0, 255)), nonce, (k == len - 1) && (kind != 1));
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset configuration: all-zero key, 20 rounds, counter starting at 0.
    // The nonce on the second byte is ignored since it falls mid-block.
    send_byte(8'h00, 64'h0, 1'b0);
    send_byte(8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    send_byte(8'hA5, 64'h0, 1'b1);
    send_byte(8'h5A, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    drain();

    // All-ones key with no double rounds; the counter wraps to zero on the
    // first block of the message.
    write_reg(CFG_KEY01, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(CFG_KEY23, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(CFG_KEY45, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(CFG_KEY67, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(CFG_ROUNDS, 64'd0);
    write_reg(CFG_START, 64'hFFFF_FFFF_FFFF_FFFF);
    end_writes();
    send_byte(8'h3C, 64'h0123_4567_89AB_CDEF, 1'b0);
    send_byte(8'hC3, 64'h0, 1'b0);
    send_byte(8'h81, 64'h0, 1'b1);
    drain();

    // An odd round count rounds down to none; the message stays open.
    write_reg(CFG_ROUNDS, 64'd1);
    write_reg(CFG_START, 64'hFFFF_FFFF_FFFF_FFFE);
    end_writes();
    send_byte(8'h7E, 64'hFFFF_FFFF_0000_0000, 1'b0);
    send_byte(8'h18, 64'h0, 1'b0);
    drain();

    // Written mid-block: the new key and round count wait for the next block
    // start, the new start counter for the next message.
    write_reg(CFG_KEY01, {$urandom(), $urandom()});
    write_reg(CFG_ROUNDS, 64'd31);
    write_reg(CFG_START, 64'h0000_0000_FFFF_FFFF);
    end_writes();
    send_byte(8'h01, 64'h0, 1'b0);
    send_byte(8'h80, 64'h0, 1'b1);
    send_byte(8'hE7, 64'h0000_0000_FFFF_FFFF, 1'b0);
    send_byte(8'h42, 64'h0, 1'b1);
    drain();

    // Round counts above twenty do not saturate; two is the smallest that runs a double round.
    write_reg(CFG_ROUNDS, 64'd21);
    end_writes();
    send_byte(8'h99, 64'hDEAD_BEEF_CAFE_F00D, 1'b0);
    send_byte(8'h66, 64'h0, 1'b1);
    drain();
    write_reg(CFG_ROUNDS, 64'd2);
    end_writes();
    send_byte(8'h0F, 64'h8000_0000_0000_0001, 1'b0);
    send_byte(8'hF0, 64'h0, 1'b0);
    send_byte(8'h55, 64'h0, 1'b1);
    drain();

    // Random phases. Every phase boundary waits for all owed bytes, so the
    // register writes land while the block is idle, and the sender is paused
    // until the queue is empty at least once per phase.
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      drain();
      if ($urandom_range(0, 2) == 0) write_reg(CFG_KEY01, pick_wide());
      if ($urandom_range(0, 2) == 0) write_reg(CFG_KEY23, pick_wide());
      if ($urandom_range(0, 2) == 0) write_reg(CFG_KEY45, pick_wide());
      if ($urandom_range(0, 2) == 0) write_reg(CFG_KEY67, pick_wide());
      if ($urandom_range(0, 2) == 0) write_reg(CFG_ROUNDS, pick_rounds());
      if ($urandom_range(0, 2) == 0) write_reg(CFG_START, pick_wide());
      end_writes();
      in_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 8;
      out_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
      repeat ($urandom_range(1, 4)) begin
        send_message();
        if ($urandom_range(0, 7) == 0) drain();
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.pending() != 0)
      $display("%0t: %0d expected result bytes never arrived", $time, sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: chacha_keystream_xor.f
hdl/ckx_pkg.sv
hdl/ckx_mix_unit.sv
hdl/chacha_keystream_xor.sv
hdl/ckx_checker.sv
tb/sv/tb_chacha_keystream_xor.sv
